[rtl/sfod_pkg.sv]
package sfod_pkg;

    localparam int HISTORY_DEPTH = 64;

    localparam int BAND_W   = 15;
    localparam int TIME_W   = 64;
    localparam int GAIN_W   = 16;
    localparam int REFR_W   = 24;
    localparam int FLUX_W   = 17;
    localparam int THR_W    = 20;
    localparam int STR_W    = 16;
    localparam int WEIGHT_W = 16;
    localparam int MUL_W    = 32;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;
    localparam int FRAC_SH  = 12;
    localparam int ROUND_SH = 15;

    localparam int AW      = $clog2(HISTORY_DEPTH);
    localparam int CW      = $clog2(HISTORY_DEPTH + 1);
    localparam int FACC_W  = BAND_W + WEIGHT_W + 3;
    localparam int S1_W    = FLUX_W + CW;
    localparam int S2_W    = 2 * FLUX_W + CW;
    localparam int D_W     = S2_W + CW;
    localparam int SQ_TOP  = ((D_W - 1) / 2) * 2;
    localparam int R_W     = (D_W + 1) / 2;
    localparam int NUM_W   = (((GAIN_W + R_W) > (S1_W + FRAC_SH)) ?
                              (GAIN_W + R_W) : (S1_W + FRAC_SH)) + 2;
    localparam int DEN_W   = FRAC_SH + CW;
    localparam int DIV_W   = (THR_W > DEN_W) ? THR_W : DEN_W;
    localparam int DIV_CW  = $clog2(NUM_W + 1);

    localparam logic [FLUX_W-1:0] FLUX_MAX       = '1;
    localparam logic [THR_W-1:0]  THR_MAX        = '1;
    localparam logic [STR_W-1:0]  STR_MAX        = STR_W'(32768);
    localparam logic [TIME_W-1:0] LAST_ONSET_RST = 64'hC000_0000_0000_0000;
    localparam logic [GAIN_W-1:0] GAIN_RST       = GAIN_W'(7373);
    localparam logic [REFR_W-1:0] REFR_RST       = REFR_W'(150000);
    localparam logic [FLUX_W-1:0] FLOOR_RST      = FLUX_W'(655);

    localparam logic [WEIGHT_W-1:0] BAND_COEF [4] =
        '{16'd32768, 16'd19661, 16'd9830, 16'd4915};

    typedef enum logic [1:0] {
        REG_THRESHOLD_GAIN  = 2'd0,
        REG_REFRACTORY_TIME = 2'd1,
        REG_THR_FLOOR       = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        MD_NONE = 3'd0,
        MD_FLUX = 3'd1,
        MD_S2   = 3'd2,
        MD_SQ   = 3'd3,
        MD_NLO  = 3'd4,
        MD_NHI  = 3'd5,
        MD_GR   = 3'd6
    } mul_dst_t;

endpackage

[rtl/sfod_if.sv]
interface sfod_frame_if
    import sfod_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [BAND_W-1:0]        band_zero;
    logic [BAND_W-1:0]        band_one;
    logic [BAND_W-1:0]        band_two;
    logic [BAND_W-1:0]        band_three;
    logic signed [TIME_W-1:0] time_us;

    modport source (output valid, band_zero, band_one, band_two, band_three, time_us,
                    input ready);
    modport sink   (input valid, band_zero, band_one, band_two, band_three, time_us,
                    output ready);
endinterface

interface sfod_result_if
    import sfod_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              onset;
    logic [STR_W-1:0]  strength;
    logic [FLUX_W-1:0] flux_value;
    logic [THR_W-1:0]  threshold_value;

    modport source (output valid, onset, strength, flux_value, threshold_value,
                    input ready);
    modport sink   (input valid, onset, strength, flux_value, threshold_value,
                    output ready);
endinterface

[rtl/spectral_flux_onset_detector.sv]
// Channel     Dir  Handshake      Payload
// frame_in    in   valid/ready    band_zero..band_three, time_us
// result_out  out  valid/ready    onset, strength, flux_value, threshold_value
// apb         in   psel/penable   threshold_gain, refractory_time, thr_floor
//
// First frame: no flux work. Later frames run the flux, history, square root and
// division steps (the last two skipped while the history is empty), plus a second
// division when an onset has a nonzero threshold, using the 42-step serial divider,
// the 24-step square root and one history read per cycle through one multiplier.
// rst_n clears control state at once; no clearing pass. A waiting result holds in
// the output register and blocks only the end of the next frame.
module spectral_flux_onset_detector
    import sfod_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    sfod_frame_if.sink          frame_in,
    sfod_result_if.source       result_out,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    typedef enum logic [16:0] {
        ST_IDLE   = 17'h00001,
        ST_FLUX   = 17'h00002,
        ST_HIST   = 17'h00004,
        ST_STQ    = 17'h00008,
        ST_SNL    = 17'h00010,
        ST_SNH    = 17'h00020,
        ST_SWAIT  = 17'h00040,
        ST_DCALC  = 17'h00080,
        ST_SQRT   = 17'h00100,
        ST_GR     = 17'h00200,
        ST_GRW    = 17'h00400,
        ST_DSTART = 17'h00800,
        ST_DIVW   = 17'h01000,
        ST_THR    = 17'h02000,
        ST_ONS    = 17'h04000,
        ST_SDIV   = 17'h08000,
        ST_DONE   = 17'h10000
    } state_t;

    state_t              state_reg, state_next;

    logic [GAIN_W-1:0]   gain_reg;
    logic [REFR_W-1:0]   refr_reg;
    logic [FLUX_W-1:0]   floor_reg;

    logic                primed_reg;
    logic [BAND_W-1:0]   bands_reg [4];
    logic [BAND_W-1:0]   prev_reg  [4];
    logic [TIME_W-1:0]   time_reg;
    logic [1:0]          j_reg;
    logic [FACC_W-1:0]   acc_reg;

    logic [FLUX_W-1:0]   hist_mem [HISTORY_DEPTH];
    logic [FLUX_W-1:0]   hdata_reg;
    logic [CW-1:0]       k_reg;
    logic                v1_reg;
    logic [S1_W-1:0]     s1_reg;
    logic [S2_W-1:0]     s2_reg;

    logic [MUL_W-1:0]    mul_a, mul_b;
    logic                mul_go;
    mul_dst_t            mul_dst;
    logic [2*MUL_W-1:0]  prod_reg;
    logic                pv_reg;
    mul_dst_t            pdst_reg;

    logic [D_W-1:0]      sq_reg, ns2_reg;
    logic [D_W-1:0]      rem_reg, res_reg, bit_reg;
    logic [D_W-1:0]      trial;
    logic                trial_ge;
    logic [NUM_W-1:0]    num_reg;
    logic [NUM_W-1:0]    tq_reg;

    logic [AW-1:0]       wr_idx_reg;
    logic [CW-1:0]       count_reg;
    logic [TIME_W-1:0]   last_reg;
    logic [FLUX_W-1:0]   lflux_reg;
    logic [THR_W-1:0]    lthr_reg;
    logic                onset_reg;
    logic [STR_W-1:0]    strength_reg;

    logic                ov_reg;
    logic                o_onset_reg;
    logic [STR_W-1:0]    o_str_reg;
    logic [FLUX_W-1:0]   o_flux_reg;
    logic [THR_W-1:0]    o_thr_reg;

    logic                accept;
    logic                issue;
    logic                load_out;
    logic [BAND_W-1:0]   sel_band, sel_prev, rise;
    logic [FACC_W-1:0]   fsum;
    logic [FLUX_W-1:0]   flux_fin;
    logic [NUM_W-1:0]    t_floor;
    logic [THR_W-1:0]    thr_fin;
    logic                fire;
    logic                early;
    logic [TIME_W-1:0]   elapsed;
    logic [FLUX_W-1:0]   diff;
    logic                div_start, div_done;
    logic [NUM_W-1:0]    div_dividend, div_quotient;
    logic [DIV_W-1:0]    div_divisor;
    logic                cfg_wr;
    reg_idx_t            cfg_idx;

    function automatic logic [STR_W-1:0] clamp_str(input logic [NUM_W-1:0] v);
        return (v > NUM_W'(STR_MAX)) ? STR_MAX : v[STR_W-1:0];
    endfunction

    assign accept   = frame_in.valid && frame_in.ready;
    assign frame_in.ready = (state_reg == ST_IDLE);
    assign issue    = (state_reg == ST_HIST) && (k_reg < count_reg);
    assign load_out = (state_reg == ST_DONE) && (!ov_reg || result_out.ready);

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign pready  = 1'b1;

    always_comb
    begin
        unique case (cfg_idx)
            REG_THRESHOLD_GAIN:  prdata = PDATA_W'(gain_reg);
            REG_REFRACTORY_TIME: prdata = PDATA_W'(refr_reg);
            REG_THR_FLOOR:       prdata = PDATA_W'(floor_reg);
            default:             prdata = '0;
        endcase
    end

    always_comb
    begin
        sel_band = bands_reg[j_reg];
        sel_prev = prev_reg[j_reg];
        rise     = (sel_band > sel_prev) ? sel_band - sel_prev : '0;

        fsum     = acc_reg + FACC_W'(16384);
        flux_fin = ((fsum >> ROUND_SH) > FACC_W'(FLUX_MAX)) ? FLUX_MAX
                 : fsum[ROUND_SH +: FLUX_W];

        t_floor  = (tq_reg < NUM_W'(floor_reg)) ? NUM_W'(floor_reg) : tq_reg;
        thr_fin  = (t_floor > NUM_W'(THR_MAX)) ? THR_MAX : t_floor[THR_W-1:0];

        trial    = res_reg + bit_reg;
        trial_ge = rem_reg >= trial;

        early    = $signed(time_reg) < $signed(last_reg);
        elapsed  = time_reg - last_reg;
        fire     = (count_reg >= CW'(HISTORY_DEPTH / 4))
                && (THR_W'(lflux_reg) > lthr_reg)
                && (early || (elapsed >= TIME_W'(refr_reg)));
        diff     = lflux_reg - lthr_reg[FLUX_W-1:0];
    end

    always_comb
    begin
        mul_a   = '0;
        mul_b   = '0;
        mul_go  = 1'b0;
        mul_dst = MD_NONE;
        unique case (state_reg)
            ST_FLUX:
            begin
                mul_a   = MUL_W'(rise);
                mul_b   = MUL_W'(BAND_COEF[j_reg]);
                mul_go  = 1'b1;
                mul_dst = MD_FLUX;
            end
            ST_HIST:
            begin
                mul_a   = MUL_W'(hdata_reg);
                mul_b   = MUL_W'(hdata_reg);
                mul_go  = v1_reg;
                mul_dst = MD_S2;
            end
            ST_STQ:
            begin
                mul_a   = MUL_W'(s1_reg);
                mul_b   = MUL_W'(s1_reg);
                mul_go  = 1'b1;
                mul_dst = MD_SQ;
            end
            ST_SNL:
            begin
                mul_a   = MUL_W'(count_reg);
                mul_b   = s2_reg[MUL_W-1:0];
                mul_go  = 1'b1;
                mul_dst = MD_NLO;
            end
            ST_SNH:
            begin
                mul_a   = MUL_W'(count_reg);
                mul_b   = MUL_W'(s2_reg[S2_W-1:MUL_W]);
                mul_go  = 1'b1;
                mul_dst = MD_NHI;
            end
            ST_GR:
            begin
                mul_a   = MUL_W'(gain_reg);
                mul_b   = MUL_W'(res_reg[R_W-1:0]);
                mul_go  = 1'b1;
                mul_dst = MD_GR;
            end
            default:
            begin
                mul_go  = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        div_start = (state_reg == ST_DSTART)
                 || ((state_reg == ST_ONS) && fire && (lthr_reg != '0));
        if (state_reg == ST_DSTART)
        begin
            div_dividend = num_reg + NUM_W'({count_reg, {(FRAC_SH - 1){1'b0}}});
            div_divisor  = DIV_W'({count_reg, {FRAC_SH{1'b0}}});
        end
        else
        begin
            div_dividend = NUM_W'({diff, {ROUND_SH{1'b0}}});
            div_divisor  = DIV_W'(lthr_reg);
        end
    end

    sfod_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (accept) state_next = primed_reg ? ST_FLUX : ST_DONE;
            ST_FLUX:   if (j_reg == 2'd3) state_next = ST_HIST;
            ST_HIST:
            begin
                if (count_reg == '0)
                    state_next = ST_THR;
                else if ((k_reg == count_reg) && !v1_reg && !pv_reg)
                    state_next = ST_STQ;
            end
            ST_STQ:    state_next = ST_SNL;
            ST_SNL:    state_next = ST_SNH;
            ST_SNH:    state_next = ST_SWAIT;
            ST_SWAIT:  state_next = ST_DCALC;
            ST_DCALC:  state_next = ST_SQRT;
            ST_SQRT:   if (bit_reg[0]) state_next = ST_GR;
            ST_GR:     state_next = ST_GRW;
            ST_GRW:    state_next = ST_DSTART;
            ST_DSTART: state_next = ST_DIVW;
            ST_DIVW:   if (div_done) state_next = ST_THR;
            ST_THR:    state_next = ST_ONS;
            ST_ONS:    state_next = div_start ? ST_SDIV : ST_DONE;
            ST_SDIV:   if (div_done) state_next = ST_DONE;
            ST_DONE:   if (load_out) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            gain_reg   <= GAIN_RST;
            refr_reg   <= REFR_RST;
            floor_reg  <= FLOOR_RST;
            primed_reg <= 1'b0;
            j_reg      <= '0;
            k_reg      <= '0;
            v1_reg     <= 1'b0;
            pv_reg     <= 1'b0;
            wr_idx_reg <= '0;
            count_reg  <= '0;
            last_reg   <= LAST_ONSET_RST;
            lflux_reg  <= '0;
            lthr_reg   <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pv_reg    <= mul_go;
            v1_reg    <= issue;

            if (cfg_wr)
            begin
                unique case (cfg_idx)
                    REG_THRESHOLD_GAIN:  gain_reg  <= pwdata[GAIN_W-1:0];
                    REG_REFRACTORY_TIME: refr_reg  <= pwdata[REFR_W-1:0];
                    REG_THR_FLOOR:       floor_reg <= pwdata[FLUX_W-1:0];
                    default:             ;
                endcase
            end

            if (accept)
            begin
                primed_reg <= 1'b1;
                j_reg      <= '0;
                k_reg      <= '0;
            end
            if (state_reg == ST_FLUX)
                j_reg <= j_reg + 1'b1;
            if (issue)
                k_reg <= k_reg + 1'b1;

            if (state_reg == ST_THR)
            begin
                lflux_reg  <= flux_fin;
                lthr_reg   <= thr_fin;
                wr_idx_reg <= (wr_idx_reg == AW'(HISTORY_DEPTH - 1)) ? '0
                            : wr_idx_reg + 1'b1;
                if (count_reg < CW'(HISTORY_DEPTH))
                    count_reg <= count_reg + 1'b1;
            end

            if ((state_reg == ST_ONS) && fire)
                last_reg <= time_reg;

            if (load_out)
                ov_reg <= 1'b1;
            else if (ov_reg && result_out.ready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_THR)
            hist_mem[wr_idx_reg] <= flux_fin;
        hdata_reg <= hist_mem[k_reg[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        pdst_reg <= mul_dst;

        if (accept)
        begin
            bands_reg[0] <= frame_in.band_zero;
            bands_reg[1] <= frame_in.band_one;
            bands_reg[2] <= frame_in.band_two;
            bands_reg[3] <= frame_in.band_three;
            time_reg     <= frame_in.time_us;
            acc_reg      <= '0;
            s1_reg       <= '0;
            s2_reg       <= '0;
            tq_reg       <= '0;
            onset_reg    <= 1'b0;
            strength_reg <= '0;
            if (!primed_reg)
            begin
                prev_reg[0] <= frame_in.band_zero;
                prev_reg[1] <= frame_in.band_one;
                prev_reg[2] <= frame_in.band_two;
                prev_reg[3] <= frame_in.band_three;
            end
        end

        if ((state_reg == ST_FLUX) && (j_reg == 2'd3))
            prev_reg <= bands_reg;

        if (v1_reg)
            s1_reg <= s1_reg + S1_W'(hdata_reg);

        if (pv_reg)
        begin
            case (pdst_reg)
                MD_FLUX: acc_reg <= acc_reg + FACC_W'(prod_reg);
                MD_S2:   s2_reg  <= s2_reg + S2_W'(prod_reg);
                MD_SQ:   sq_reg  <= D_W'(prod_reg);
                MD_NLO:  ns2_reg <= D_W'(prod_reg);
                MD_NHI:  ns2_reg <= ns2_reg + {prod_reg[D_W-MUL_W-1:0], {MUL_W{1'b0}}};
                MD_GR:   num_reg <= NUM_W'({s1_reg, {FRAC_SH{1'b0}}}) + NUM_W'(prod_reg);
                default: ;
            endcase
        end

        if (state_reg == ST_DCALC)
        begin
            rem_reg <= (ns2_reg > sq_reg) ? ns2_reg - sq_reg : '0;
            res_reg <= '0;
            bit_reg <= D_W'(1) << SQ_TOP;
        end
        else if (state_reg == ST_SQRT)
        begin
            if (trial_ge)
            begin
                rem_reg <= rem_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end

        if ((state_reg == ST_DIVW) && div_done)
            tq_reg <= div_quotient;

        if (state_reg == ST_ONS)
        begin
            onset_reg    <= fire;
            strength_reg <= (fire && (lthr_reg == '0)) ? clamp_str(NUM_W'(diff)) : '0;
        end
        if ((state_reg == ST_SDIV) && div_done)
            strength_reg <= clamp_str(div_quotient);

        if (load_out)
        begin
            o_onset_reg <= onset_reg;
            o_str_reg   <= strength_reg;
            o_flux_reg  <= lflux_reg;
            o_thr_reg   <= lthr_reg;
        end
    end

    assign result_out.valid           = ov_reg;
    assign result_out.onset           = o_onset_reg;
    assign result_out.strength        = o_str_reg;
    assign result_out.flux_value      = o_flux_reg;
    assign result_out.threshold_value = o_thr_reg;

endmodule

[rtl/sfod_div.sv]
module sfod_div
    import sfod_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    logic [DIV_W:0]      rem_reg;
    logic [NUM_W-1:0]    quo_reg;
    logic [DIV_W-1:0]    dsr_reg;
    logic [DIV_CW-1:0]   cnt_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [DIV_W:0]      shifted;
    logic                fits;

    always_comb
    begin
        shifted = {rem_reg[DIV_W-1:0], quo_reg[NUM_W-1]};
        fits    = shifted >= {1'b0, dsr_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CW'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? shifted - {1'b0, dsr_reg} : shifted;
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[rtl/sfod_chk.sv]
module sfod_chk
    import sfod_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic              onset,
    input logic [STR_W-1:0]  strength,
    input logic [FLUX_W-1:0] flux_value,
    input logic [THR_W-1:0]  threshold_value
);

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("frame accepted while previous frame in work");

    a_strength_needs_onset: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !onset) |-> (strength == '0))
        else $error("strength without onset");

    a_strength_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (strength <= STR_MAX))
        else $error("strength above clamp");

    a_onset_above_thr: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && onset) |-> (THR_W'(flux_value) > threshold_value))
        else $error("onset with flux not above threshold");

    a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped before transaction");

endmodule

bind spectral_flux_onset_detector sfod_chk u_sfod_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (frame_in.valid),
    .in_ready        (frame_in.ready),
    .out_valid       (result_out.valid),
    .out_ready       (result_out.ready),
    .onset           (result_out.onset),
    .strength        (result_out.strength),
    .flux_value      (result_out.flux_value),
    .threshold_value (result_out.threshold_value)
);

[dv/spectral_flux_onset_detector_test.sv]
module spectral_flux_onset_detector_test;
    import sfod_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int HOLD_CYCLES = 600;

    typedef struct {
        logic [BAND_W-1:0]        band [4];
        logic signed [TIME_W-1:0] tm;
    } frame_t;

    typedef struct {
        logic              onset;
        logic [STR_W-1:0]  strength;
        logic [FLUX_W-1:0] flux;
        logic [THR_W-1:0]  thr;
    } detection_t;

    typedef struct {
        logic [BAND_W-1:0]        b0, b1, b2, b3;
        logic signed [TIME_W-1:0] tm;
        bit                       typed;
        detection_t               exp;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    sfod_frame_if  frame_in_if();
    sfod_result_if result_if();

    spectral_flux_onset_detector DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame_in   (frame_in_if.sink),
        .result_out (result_if.source),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    int unsigned cycles = 0;
    int unsigned error_count = 0;
    bit steady = 1'b0;
    bit hold_req = 1'b0;
    detection_t detection_q [$];

    // predictor state
    logic [GAIN_W-1:0]  gain_r;
    logic [REFR_W-1:0]  refr_r;
    logic [FLUX_W-1:0]  floor_r;
    logic [BAND_W-1:0]  prev_band [4];
    bit                 primed;
    logic [FLUX_W-1:0]  flux_hist [HISTORY_DEPTH];
    int unsigned        hist_wr;
    int unsigned        hist_cnt;
    logic [63:0]        last_onset;
    logic [FLUX_W-1:0]  pred_flux;
    logic [THR_W-1:0]   pred_thr;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic detection_t detect_onset(frame_t f);
        detection_t r;
        logic [63:0] acc, s1, s2, n, d, rt, num, den, t, s, h;
        logic [FLUX_W-1:0] flux;
        logic [THR_W-1:0] thr;
        bit fire;
        r.onset = 1'b0;
        r.strength = '0;
        if (!primed)
        begin
            for (int i = 0; i < 4; i++)
                prev_band[i] = f.band[i];
            primed = 1'b1;
        end
        else
        begin
            acc = 0;
            for (int i = 0; i < 4; i++)
                if (f.band[i] > prev_band[i])
                    acc += 64'(f.band[i] - prev_band[i]) * 64'(BAND_COEF[i]);
            for (int i = 0; i < 4; i++)
                prev_band[i] = f.band[i];
            acc = (acc + 64'd16384) >> 15;
            flux = (acc > 64'(FLUX_MAX)) ? FLUX_MAX : FLUX_W'(acc);
            t = 0;
            n = hist_cnt;
            if (n > 0)
            begin
                s1 = 0;
                s2 = 0;
                for (int k = 0; k < hist_cnt; k++)
                begin
                    h = 64'(flux_hist[k]);
                    s1 += h;
                    s2 += h * h;
                end
                d = n * s2;
                d = (d > s1 * s1) ? d - s1 * s1 : 64'd0;
                rt = int_sqrt(d);
                num = s1 * 4096 + 64'(gain_r) * rt;
                den = 4096 * n;
                t = (num + den / 2) / den;
            end
            if (t < 64'(floor_r))
                t = 64'(floor_r);
            thr = (t > 64'(THR_MAX)) ? THR_MAX : THR_W'(t);
            pred_flux = flux;
            pred_thr = thr;
            flux_hist[hist_wr] = flux;
            hist_wr = (hist_wr + 1) % HISTORY_DEPTH;
            if (hist_cnt < HISTORY_DEPTH)
                hist_cnt++;
            if (hist_cnt >= HISTORY_DEPTH / 4 && 20'(flux) > thr)
            begin
                if ($signed(f.tm) < $signed(last_onset))
                    fire = 1'b1;
                else
                    fire = (64'(f.tm) - last_onset) >= 64'(refr_r);
                if (fire)
                begin
                    last_onset = f.tm;
                    r.onset = 1'b1;
                    if (thr > 0)
                        s = (64'(20'(flux) - thr) << 15) / 64'(thr);
                    else
                        s = 64'(20'(flux) - thr);
                    r.strength = (s > 64'd32768) ? STR_MAX : STR_W'(s);
                end
            end
        end
        r.flux = pred_flux;
        r.thr = pred_thr;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
        error_count++;
    endtask

    task automatic write_reg(reg_idx_t idx, logic [1:0] raw_idx, bit known, logic [31:0] value);
        logic [1:0] a;
        a = known ? 2'(idx) : raw_idx;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(4 * a);
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (known)
            case (idx)
                REG_THRESHOLD_GAIN:  gain_r = value[GAIN_W-1:0];
                REG_REFRACTORY_TIME: refr_r = value[REFR_W-1:0];
                REG_THR_FLOOR:       floor_r = value[FLUX_W-1:0];
                default: ;
            endcase
    endtask

    task automatic send_frame(frame_t f, bit typed, detection_t typed_exp);
        int unsigned gap;
        detection_t p;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            frame_in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        frame_in_if.valid      <= 1'b1;
        frame_in_if.band_zero  <= f.band[0];
        frame_in_if.band_one   <= f.band[1];
        frame_in_if.band_two   <= f.band[2];
        frame_in_if.band_three <= f.band[3];
        frame_in_if.time_us    <= f.tm;
        do @(posedge clk); while (!frame_in_if.ready);
        p = detect_onset(f);
        detection_q.push_back(typed ? typed_exp : p);
    endtask

    task automatic drain();
        frame_in_if.valid <= 1'b0;
        while (detection_q.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    initial
    begin : result_checker
        detection_t want;
        int unsigned stall;
        result_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                result_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            stall = steady ? 0 : $urandom_range(0, 3);
            if (stall > 0)
            begin
                result_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_if.ready <= 1'b1;
            do @(posedge clk); while (!(result_if.valid && result_if.ready));
            if (detection_q.size() == 0)
            begin
                report_mismatch("unexpected result flux", 64'(result_if.flux_value), 64'd0);
            end
            else
            begin
                want = detection_q.pop_front();
                if (result_if.onset !== want.onset)
                    report_mismatch("onset", 64'(result_if.onset), 64'(want.onset));
                if (result_if.strength !== want.strength)
                    report_mismatch("strength", 64'(result_if.strength), 64'(want.strength));
                if (result_if.flux_value !== want.flux)
                    report_mismatch("flux", 64'(result_if.flux_value), 64'(want.flux));
                if (result_if.threshold_value !== want.thr)
                    report_mismatch("threshold", 64'(result_if.threshold_value), 64'(want.thr));
            end
        end
    end

    localparam logic signed [63:0] T_MIN = 64'h8000_0000_0000_0000;
    localparam logic signed [63:0] T_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam detection_t NO_DET = '{1'b0, '0, '0, '0};
    localparam detection_t FLOOR_DET = '{1'b0, '0, '0, THR_W'(655)};

    stim_row_t directed [] = '{
        '{15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 64'sd0,    1'b1, NO_DET},
        '{15'h0000, 15'h0000, 15'h0000, 15'h0000, 64'sd1000, 1'b1, FLOOR_DET},
        '{15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 64'sd2000, 1'b0, NO_DET},
        '{15'h0000, 15'h0000, 15'h0000, 15'h0000, 64'sd3000, 1'b0, NO_DET},
        '{15'h7FFF, 15'h0000, 15'h0000, 15'h0000, 64'sd4000, 1'b0, NO_DET},
        '{15'h0000, 15'h7FFF, 15'h0000, 15'h0000, 64'sd5000, 1'b0, NO_DET},
        '{15'h0000, 15'h0000, 15'h7FFF, 15'h0000, 64'sd6000, 1'b0, NO_DET},
        '{15'h0000, 15'h0000, 15'h0000, 15'h7FFF, 64'sd7000, 1'b0, NO_DET},
        '{15'h0001, 15'h0001, 15'h0001, 15'h0001, 64'sd8000, 1'b0, NO_DET},
        '{15'h0001, 15'h0001, 15'h0001, 15'h0001, 64'sd9000, 1'b0, NO_DET},
        '{15'h0100, 15'h0100, 15'h0100, 15'h0100, 64'sd10000, 1'b0, NO_DET},
        '{15'h0100, 15'h0100, 15'h0100, 15'h0100, 64'sd11000, 1'b0, NO_DET},
        '{15'h0200, 15'h0200, 15'h0200, 15'h0200, 64'sd12000, 1'b0, NO_DET},
        '{15'h0200, 15'h0200, 15'h0200, 15'h0200, 64'sd13000, 1'b0, NO_DET},
        '{15'h0300, 15'h0300, 15'h0300, 15'h0300, 64'sd14000, 1'b0, NO_DET},
        '{15'h0300, 15'h0300, 15'h0300, 15'h0300, 64'sd15000, 1'b0, NO_DET},
        '{15'h0000, 15'h0000, 15'h0000, 15'h0000, 64'sd16000, 1'b0, NO_DET},
        '{15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 64'sd17000, 1'b0, NO_DET},
        '{15'h0000, 15'h0000, 15'h0000, 15'h0000, 64'sd18000, 1'b0, NO_DET},
        '{15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, 64'sd19000, 1'b0, NO_DET},
        '{15'h0000, 15'h0000, 15'h0000, 15'h0000, T_MAX,      1'b0, NO_DET},
        '{15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, T_MIN,      1'b0, NO_DET},
        '{15'h0000, 15'h0000, 15'h0000, 15'h0000, T_MIN,      1'b0, NO_DET},
        '{15'h7FFF, 15'h7FFF, 15'h7FFF, 15'h7FFF, T_MAX,      1'b0, NO_DET}
    };

    logic signed [63:0] clock_us;
    logic [BAND_W-1:0]  base_band [4];

    task automatic make_frame(bit flat, output frame_t f);
        int unsigned kind;
        kind = $urandom_range(0, 19);
        if (kind == 0)
        begin
            for (int i = 0; i < 4; i++)
                f.band[i] = BAND_W'($urandom);
            f.tm = {$urandom, $urandom};
            return;
        end
        if (kind == 1)
            clock_us = clock_us - 64'($urandom_range(1, 500000));
        else
            clock_us = clock_us + 64'($urandom_range(0, 200000));
        for (int i = 0; i < 4; i++)
        begin
            if (kind == 2 || kind == 3)
                f.band[i] = BAND_W'($urandom_range(8000, 32767));
            else if (flat)
                f.band[i] = base_band[i];
            else
                f.band[i] = BAND_W'($urandom_range(0, 1)
                            ? base_band[i] + BAND_W'($urandom_range(0, 600))
                            : base_band[i]);
        end
        if (kind == 4)
            for (int i = 0; i < 4; i++)
                base_band[i] = BAND_W'($urandom_range(0, 12000));
        f.tm = clock_us;
    endtask

    task automatic run_phase(int unsigned count, bit flat, bit hold);
        frame_t f;
        if (hold)
            hold_req = 1'b1;
        for (int n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
                steady = ($urandom_range(0, 3) == 0);
            make_frame(flat, f);
            send_frame(f, 1'b0, NO_DET);
        end
        steady = 1'b0;
        drain();
    endtask

    initial
    begin : stimulus
        frame_t f;
        frame_in_if.valid      = 1'b0;
        frame_in_if.band_zero  = '0;
        frame_in_if.band_one   = '0;
        frame_in_if.band_two   = '0;
        frame_in_if.band_three = '0;
        frame_in_if.time_us    = '0;
        gain_r = GAIN_RST;
        refr_r = REFR_RST;
        floor_r = FLOOR_RST;
        for (int i = 0; i < 4; i++)
        begin
            prev_band[i] = '0;
            base_band[i] = BAND_W'(1000 * (i + 1));
        end
        primed = 1'b0;
        hist_wr = 0;
        hist_cnt = 0;
        last_onset = LAST_ONSET_RST;
        pred_flux = '0;
        pred_thr = '0;
        clock_us = 64'sd100000;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            f.band[0] = directed[i].b0;
            f.band[1] = directed[i].b1;
            f.band[2] = directed[i].b2;
            f.band[3] = directed[i].b3;
            f.tm = directed[i].tm;
            send_frame(f, directed[i].typed, directed[i].exp);
        end
        drain();

        run_phase(120, 1'b0, 1'b1);

        write_reg(REG_THRESHOLD_GAIN, 2'd0, 1'b1, 32'd0);
        write_reg(REG_REFRACTORY_TIME, 2'd0, 1'b1, 32'd0);
        write_reg(REG_THR_FLOOR, 2'd0, 1'b1, 32'd0);
        run_phase(110, 1'b1, 1'b0);

        write_reg(REG_THRESHOLD_GAIN, 2'd0, 1'b1, 32'd65535);
        write_reg(REG_REFRACTORY_TIME, 2'd0, 1'b1, 32'd10000000);
        write_reg(REG_THR_FLOOR, 2'd0, 1'b1, 32'd131071);
        write_reg(REG_THRESHOLD_GAIN, 2'd3, 1'b0, 32'hFFFF_FFFF);
        run_phase(110, 1'b0, 1'b0);

        write_reg(REG_THRESHOLD_GAIN, 2'd0, 1'b1, 32'd2048);
        write_reg(REG_REFRACTORY_TIME, 2'd0, 1'b1, 32'd40000);
        write_reg(REG_THR_FLOOR, 2'd0, 1'b1, 32'd50);
        run_phase(130, 1'b0, 1'b1);

        write_reg(REG_THRESHOLD_GAIN, 2'd0, 1'b1, 32'($urandom_range(0, 65535)));
        write_reg(REG_REFRACTORY_TIME, 2'd0, 1'b1, 32'($urandom_range(0, 10000000)));
        write_reg(REG_THR_FLOOR, 2'd0, 1'b1, 32'($urandom_range(0, 2000)));
        run_phase(130, 1'b0, 1'b0);

        write_reg(REG_THRESHOLD_GAIN, 2'd0, 1'b1, 32'd7373);
        write_reg(REG_REFRACTORY_TIME, 2'd0, 1'b1, 32'd150000);
        write_reg(REG_THR_FLOOR, 2'd0, 1'b1, 32'd655);
        run_phase(130, 1'b0, 1'b0);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[filelist.f]
rtl/sfod_pkg.sv
rtl/sfod_if.sv
rtl/sfod_div.sv
rtl/spectral_flux_onset_detector.sv
rtl/sfod_chk.sv
dv/spectral_flux_onset_detector_test.sv
